// ===== hdl/pwc_pkg.sv =====
// Shared constants and types for the four-channel pulse width capture block.
package pwc_pkg;

	localparam int NUM_CHANNELS  = 4;
	localparam int OVERFLOW_BITS = 6;
	localparam int CAP_BITS      = 16;
	localparam int WIDTH_BITS    = OVERFLOW_BITS + CAP_BITS;

	localparam logic [OVERFLOW_BITS-1:0] COUNT_MAX = {OVERFLOW_BITS{1'b1}};
	localparam logic [CAP_BITS-1:0]      CAP_SAT   = {CAP_BITS{1'b1}};

	typedef logic [OVERFLOW_BITS-1:0] ovf_count_t;
	typedef logic [CAP_BITS-1:0]      cap_value_t;
	typedef logic [WIDTH_BITS-1:0]    pulse_width_t;

	// Per-channel result of one event, as seen by the top level.
	typedef struct packed {
		pulse_width_t width;
		logic         falling;
		logic         clear_req;
	} chan_res_t;

endpackage

// ===== hdl/pwc_if.sv =====
// Valid/ready channel interfaces for timer events and capture results.
interface pwc_in_if import pwc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    overflow_flag;
	logic [NUM_CHANNELS-1:0] capture_flags;
	cap_value_t              capture_value_1;
	cap_value_t              capture_value_2;
	cap_value_t              capture_value_3;
	cap_value_t              capture_value_4;

	modport source (
		output valid, overflow_flag, capture_flags,
		output capture_value_1, capture_value_2, capture_value_3, capture_value_4,
		input  ready
	);
	modport sink (
		input  valid, overflow_flag, capture_flags,
		input  capture_value_1, capture_value_2, capture_value_3, capture_value_4,
		output ready
	);
endinterface

interface pwc_out_if import pwc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	pulse_width_t            width_1;
	pulse_width_t            width_2;
	pulse_width_t            width_3;
	pulse_width_t            width_4;
	logic [NUM_CHANNELS-1:0] falling_edge_select;
	logic                    clear_counter;

	modport source (
		output valid, width_1, width_2, width_3, width_4,
		output falling_edge_select, clear_counter,
		input  ready
	);
	modport sink (
		input  valid, width_1, width_2, width_3, width_4,
		input  falling_edge_select, clear_counter,
		output ready
	);
endinterface

// ===== hdl/pwc_channel.sv =====
// State and next-state logic of one capture channel.
module pwc_channel import pwc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       ovf,
	input  logic       cap,
	input  cap_value_t value,
	output chan_res_t  res
);

	logic         done_q, done_n;
	logic         high_q, high_n;
	logic         pol_q, pol_n;
	ovf_count_t   cnt_q, cnt_n;
	cap_value_t   held_q, held_n;
	pulse_width_t pub_q, pub_n;
	logic         clr;

	always_comb begin
		done_n = done_q;
		high_n = high_q;
		pol_n  = pol_q;
		cnt_n  = cnt_q;
		held_n = held_q;
		pub_n  = pub_q;
		clr    = 1'b0;
		if (done_q) begin
			// publish and rearm; ignore this beat's capture and overflow
			pub_n  = {cnt_q, held_q};
			done_n = 1'b0;
			high_n = 1'b0;
			cnt_n  = '0;
		end else begin
			if (ovf && high_q) begin
				if (cnt_q == COUNT_MAX) begin
					done_n = 1'b1;
					held_n = CAP_SAT;
				end else begin
					cnt_n = cnt_q + 1'b1;
				end
			end
			if (cap) begin
				if (high_q) begin
					done_n = 1'b1;
					held_n = value;
					pol_n  = 1'b0;
				end else begin
					cnt_n  = '0;
					held_n = '0;
					high_n = 1'b1;
					pol_n  = 1'b1;
					clr    = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			high_q <= 1'b0;
			pol_q  <= 1'b0;
			cnt_q  <= '0;
			held_q <= '0;
			pub_q  <= '0;
		end else if (en) begin
			done_q <= done_n;
			high_q <= high_n;
			pol_q  <= pol_n;
			cnt_q  <= cnt_n;
			held_q <= held_n;
			pub_q  <= pub_n;
		end
	end

	assign res.width     = pub_n;
	assign res.falling   = pol_n;
	assign res.clear_req = clr;

endmodule

// ===== hdl/four_channel_pulse_width_capture.sv =====
// Top level: input register, four capture channels and the result register.
//
//   channel  dir  beat contents
//   in_ch    in   overflow flag, capture flags, four captured counter values
//   out_ch   out  four published widths, falling-edge select, counter clear
//
// One beat per cycle sustained while out_ch.ready stays high; an event is held in the input register first.
// The input register feeds the channel update, which writes the result register.
// The result register and channel state advance together whenever the input register holds
// a beat and the result register is empty or being drained; in_ch.ready drops only while both stages hold.
// arst_n clears all channel state, polarity and both valid flags.
module four_channel_pulse_width_capture import pwc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	pwc_in_if.sink    in_ch,
	pwc_out_if.source out_ch
);

	logic                    valid_s1;
	logic                    ovf_s1;
	logic [NUM_CHANNELS-1:0] flags_s1;
	cap_value_t              val_s1 [NUM_CHANNELS];

	logic                    out_valid_q;
	pulse_width_t            width_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] fes_q;
	logic                    clr_q;

	chan_res_t               res [NUM_CHANNELS];
	logic                    out_free;
	logic                    adv;
	logic [NUM_CHANNELS-1:0] fes_n;
	logic [NUM_CHANNELS-1:0] clr_vec;

	assign out_free    = !out_valid_q || out_ch.ready;
	assign adv         = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			ovf_s1    <= in_ch.overflow_flag;
			flags_s1  <= in_ch.capture_flags;
			val_s1[0] <= in_ch.capture_value_1;
			val_s1[1] <= in_ch.capture_value_2;
			val_s1[2] <= in_ch.capture_value_3;
			val_s1[3] <= in_ch.capture_value_4;
		end
	end

	for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_chan
		pwc_channel u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.ovf    (ovf_s1),
			.cap    (flags_s1[ch]),
			.value  (val_s1[ch]),
			.res    (res[ch])
		);
		assign fes_n[ch]   = res[ch].falling;
		assign clr_vec[ch] = res[ch].clear_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
				width_q[ch] <= res[ch].width;
			end
			fes_q <= fes_n;
			clr_q <= |clr_vec;
		end
	end

	assign out_ch.valid               = out_valid_q;
	assign out_ch.width_1             = width_q[0];
	assign out_ch.width_2             = width_q[1];
	assign out_ch.width_3             = width_q[2];
	assign out_ch.width_4             = width_q[3];
	assign out_ch.falling_edge_select = fes_q;
	assign out_ch.clear_counter       = clr_q;

endmodule

// ===== bench/four_channel_pulse_width_capture_tb.sv =====
// Self-checking bench: random timer events in, per-event widths, edge selects and counter clear checked.
module four_channel_pulse_width_capture_tb;
	import pwc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned EVENT_COUNT = 1150;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned HOLD_AT     = 300;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned MAX_GAP     = 18;

	typedef logic [NUM_CHANNELS-1:0] lane_mask_t;

	typedef struct packed {
		logic                          overflow;
		lane_mask_t                    flags;
		cap_value_t [NUM_CHANNELS-1:0] value;
	} timer_event_t;

	typedef struct packed {
		pulse_width_t [NUM_CHANNELS-1:0] width;
		lane_mask_t                      falling;
		logic                            clear;
	} capture_result_t;

	// Per-channel pulse tracker and the queue of results it predicts.
	class pulse_width_scoreboard;
		bit              finished [NUM_CHANNELS];
		bit              high     [NUM_CHANNELS];
		ovf_count_t      ovf_count[NUM_CHANNELS];
		cap_value_t      held     [NUM_CHANNELS];
		pulse_width_t    published[NUM_CHANNELS];
		lane_mask_t      polarity;
		capture_result_t expected_results[$];
		int unsigned     errors;

		function new();
			for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
				finished[ch]  = 1'b0;
				high[ch]      = 1'b0;
				ovf_count[ch] = '0;
				held[ch]      = '0;
				published[ch] = '0;
			end
			polarity = '0;
			errors   = 0;
		endfunction

		function void note_event(timer_event_t ev);
			capture_result_t res;
			logic            clr;
			clr = 1'b0;
			for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
				// a finished channel only publishes and rearms
				if (finished[ch]) begin
					published[ch] = {ovf_count[ch], held[ch]};
					finished[ch]  = 1'b0;
					high[ch]      = 1'b0;
					ovf_count[ch] = '0;
					continue;
				end
				if (ev.overflow && high[ch]) begin
					if (ovf_count[ch] == COUNT_MAX) begin
						finished[ch] = 1'b1;
						held[ch]     = CAP_SAT;
					end else begin
						ovf_count[ch] = ovf_count[ch] + 1'b1;
					end
				end
				if (ev.flags[ch]) begin
					if (high[ch]) begin
						finished[ch] = 1'b1;
						held[ch]     = ev.value[ch];
						polarity[ch] = 1'b0;
					end else begin
						ovf_count[ch] = '0;
						held[ch]      = '0;
						high[ch]      = 1'b1;
						clr           = 1'b1;
						polarity[ch]  = 1'b1;
					end
				end
			end
			for (int ch = 0; ch < NUM_CHANNELS; ch++)
				res.width[ch] = published[ch];
			res.falling = polarity;
			res.clear   = clr;
			expected_results.push_back(res);
		endfunction

		function void check_result(capture_result_t act);
			capture_result_t exp_res;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result beat, nothing pending: %p", $time, act);
				errors++;
				return;
			end
			exp_res = expected_results.pop_front();
			for (int ch = 0; ch < NUM_CHANNELS; ch++)
				if (act.width[ch] !== exp_res.width[ch]) begin
					$display("%0t: width_%0d mismatch: expected %0d, actual %0d",
						$time, ch + 1, exp_res.width[ch], act.width[ch]);
					errors++;
				end
			if (act.falling !== exp_res.falling) begin
				$display("%0t: falling_edge_select mismatch: expected %b, actual %b",
					$time, exp_res.falling, act.falling);
				errors++;
			end
			if (act.clear !== exp_res.clear) begin
				$display("%0t: clear_counter mismatch: expected %b, actual %b",
					$time, exp_res.clear, act.clear);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		function lane_mask_t armed_mask();
			lane_mask_t m;
			for (int ch = 0; ch < NUM_CHANNELS; ch++)
				m[ch] = high[ch] && !finished[ch];
			return m;
		endfunction

		function bit at_count_max(int ch);
			return high[ch] && !finished[ch] && ovf_count[ch] == COUNT_MAX;
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pwc_in_if  in_ch ();
	pwc_out_if out_ch ();

	four_channel_pulse_width_capture u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	pulse_width_scoreboard sb = new();
	int unsigned           events_sent;
	int unsigned           cycle_count = 0;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Run of zero gaps every so often, random gaps otherwise.
	function automatic int unsigned draw_gap(int unsigned idx);
		if (idx % 97 < 20)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	function automatic cap_value_t pick_value();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return CAP_SAT;
			default: return cap_value_t'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic timer_event_t make_event(logic ovf, lane_mask_t flags,
			cap_value_t v0, cap_value_t v1, cap_value_t v2, cap_value_t v3);
		timer_event_t ev;
		ev.overflow = ovf;
		ev.flags    = flags;
		ev.value[0] = v0;
		ev.value[1] = v1;
		ev.value[2] = v2;
		ev.value[3] = v3;
		return ev;
	endfunction

	// Random event; lanes in quiet never see a capture.
	function automatic timer_event_t random_event(lane_mask_t quiet);
		timer_event_t ev;
		ev.overflow = ($urandom_range(0, 1) != 0);
		if ($urandom_range(0, 4) == 0) begin
			ev.flags = lane_mask_t'($urandom_range(0, 15));
		end else begin
			for (int ch = 0; ch < NUM_CHANNELS; ch++)
				ev.flags[ch] = ($urandom_range(0, 3) == 0);
		end
		ev.flags = ev.flags & ~quiet;
		for (int ch = 0; ch < NUM_CHANNELS; ch++)
			ev.value[ch] = pick_value();
		return ev;
	endfunction

	task automatic send_event(input timer_event_t ev);
		int unsigned gap;
		gap = draw_gap(events_sent);
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.overflow_flag   = ev.overflow;
		in_ch.capture_flags   = ev.flags;
		in_ch.capture_value_1 = ev.value[0];
		in_ch.capture_value_2 = ev.value[1];
		in_ch.capture_value_3 = ev.value[2];
		in_ch.capture_value_4 = ev.value[3];
		in_ch.valid           = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_event(ev);
		events_sent++;
	endtask

	// Arm one lane, run its overflow count to the top, then saturate it,
	// with or without a closing capture in the same event.
	task automatic run_saturation(input int lane);
		timer_event_t ev;
		lane_mask_t   m;
		m = lane_mask_t'(1) << lane;
		while ((sb.armed_mask() & m) == '0) begin
			ev = random_event(m);
			ev.flags = ev.flags | m;
			send_event(ev);
		end
		while (!sb.at_count_max(lane)) begin
			ev = random_event(m);
			ev.overflow = ($urandom_range(0, 3) != 0);
			send_event(ev);
		end
		ev = random_event(m);
		ev.overflow = 1'b1;
		if ($urandom_range(0, 1))
			ev.flags = ev.flags | m;
		send_event(ev);
	endtask

	task automatic wait_until_drained();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Result side: random stalls, one long hold-off to back the block up.
	initial begin
		int unsigned     stall;
		int unsigned     taken;
		capture_result_t act;
		out_ch.ready = 1'b0;
		taken        = 0;
		@(posedge arst_n);
		forever begin
			stall = (taken == HOLD_AT) ? HOLD_CYCLES : draw_gap(taken);
			if (stall > 0) begin
				@(negedge clk);
				out_ch.ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			act.width[0] = out_ch.width_1;
			act.width[1] = out_ch.width_2;
			act.width[2] = out_ch.width_3;
			act.width[3] = out_ch.width_4;
			act.falling  = out_ch.falling_edge_select;
			act.clear    = out_ch.clear_counter;
			sb.check_result(act);
			taken++;
		end
	end

	initial begin
		int unsigned sat_runs;
		bit          paused;
		events_sent           = 0;
		sat_runs              = 0;
		paused                = 1'b0;
		arst_n                = 1'b0;
		in_ch.valid           = 1'b0;
		in_ch.overflow_flag   = 1'b0;
		in_ch.capture_flags   = '0;
		in_ch.capture_value_1 = '0;
		in_ch.capture_value_2 = '0;
		in_ch.capture_value_3 = '0;
		in_ch.capture_value_4 = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		send_event(make_event(1'b0, 4'b0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		// overflow with no channel high is ignored
		send_event(make_event(1'b1, 4'b0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		// all four arm together and share one counter clear
		send_event(make_event(1'b1, 4'b1111, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_event(make_event(1'b1, 4'b0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_event(make_event(1'b1, 4'b0101, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000));
		// done channels publish and drop their captures
		send_event(make_event(1'b0, 4'b1111, 16'h1234, 16'h0000, 16'hA5A5, 16'hFFFF));
		send_event(make_event(1'b1, 4'b1111, 16'h5A5A, 16'hFFFF, 16'h0001, 16'h8000));
		send_event(make_event(1'b0, 4'b0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_event(make_event(1'b0, 4'b0101, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
		send_event(make_event(1'b0, 4'b0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_event(make_event(1'b0, 4'b1000, 16'h0000, 16'h0000, 16'h0000, 16'h8000));
		send_event(make_event(1'b1, 4'b1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_event(make_event(1'b0, 4'b0111, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000));
		send_event(make_event(1'b0, 4'b0111, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_event(make_event(1'b0, 4'b0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

		while (events_sent < EVENT_COUNT) begin
			if (!paused && events_sent >= EVENT_COUNT / 2) begin
				// hold the input off until every result is back
				paused = 1'b1;
				@(negedge clk);
				in_ch.valid = 1'b0;
				wait_until_drained();
			end
			if (sat_runs * 190 + 100 < events_sent) begin
				run_saturation($urandom_range(0, NUM_CHANNELS - 1));
				sat_runs++;
			end else begin
				send_event(random_event('0));
			end
		end
		@(negedge clk);
		in_ch.valid = 1'b0;

		wait_until_drained();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0t: %0d results never arrived", $time, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/pwc_pkg.sv
hdl/pwc_if.sv
hdl/pwc_channel.sv
hdl/four_channel_pulse_width_capture.sv
bench/four_channel_pulse_width_capture_tb.sv
